### src/b64d_pkg.sv
package b64d_pkg;

    // character codes
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_DASH    = 8'd45;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_UNDER   = 8'd95;
    localparam logic [7:0] CH_SLASH   = 8'd47;
    localparam logic [7:0] CH_EQUALS  = 8'd61;

    // digit offsets and fixed digits
    localparam logic [5:0] DIGIT_LOWER_BASE = 6'd26;
    localparam logic [5:0] DIGIT_NUM_BASE   = 6'd52;
    localparam logic [5:0] DIGIT_62         = 6'd62;
    localparam logic [5:0] DIGIT_63         = 6'd63;

    localparam logic [5:0] CARRY_LOW4_MASK = 6'h0f;
    localparam logic [5:0] CARRY_LOW2_MASK = 6'h03;

    // position within a group of four characters
    localparam logic [1:0] GRP_POS_FIRST  = 2'd0;
    localparam logic [1:0] GRP_POS_SECOND = 2'd1;
    localparam logic [1:0] GRP_POS_THIRD  = 2'd2;
    localparam logic [1:0] GRP_POS_FOURTH = 2'd3;

    typedef struct packed {
        logic [5:0] value;
        logic       bad;
        logic       pad;
    } b64d_digit_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       last_out;
        logic       decode_error;
    } b64d_result_t;

    typedef struct packed {
        logic [1:0] pos;
        logic       err;
    } b64d_status_t;

endpackage

### src/b64d_char_if.sv
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink (input valid, input char_in, input last_char, output ready);
endinterface

### src/b64d_byte_if.sv
interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       last_out;
    logic       decode_error;

    modport source (output valid, output byte_out, output byte_valid, output last_out,
                    output decode_error, input ready);
    modport sink (input valid, input byte_out, input byte_valid, input last_out,
                  input decode_error, output ready);
endinterface

### src/b64d_digit_map.sv
module b64d_digit_map
    import b64d_pkg::*;
(
    input  logic [7:0]  char_in,
    output b64d_digit_t digit
);

    logic [7:0] offset;

    always_comb
    begin
        offset      = 8'd0;
        digit.value = 6'd0;
        digit.bad   = 1'b0;
        digit.pad   = (char_in == CH_EQUALS);
        if (char_in >= CH_UPPER_A && char_in <= CH_UPPER_Z)
        begin
            offset      = char_in - CH_UPPER_A;
            digit.value = offset[5:0];
        end
        else if (char_in >= CH_LOWER_A && char_in <= CH_LOWER_Z)
        begin
            offset      = char_in - CH_LOWER_A;
            digit.value = offset[5:0] + DIGIT_LOWER_BASE;
        end
        else if (char_in >= CH_ZERO && char_in <= CH_NINE)
        begin
            offset      = char_in - CH_ZERO;
            digit.value = offset[5:0] + DIGIT_NUM_BASE;
        end
        else if (char_in == CH_DASH || char_in == CH_PLUS)
        begin
            digit.value = DIGIT_62;
        end
        else if (char_in == CH_UNDER || char_in == CH_SLASH)
        begin
            digit.value = DIGIT_63;
        end
        else
        begin
            // decode anything else as digit zero
            digit.bad = 1'b1;
        end
    end

endmodule

### src/b64d_group.sv
module b64d_group
    import b64d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  b64d_digit_t  digit,
    input  logic         last_char,
    output logic         has_result,
    output b64d_result_t result,
    output b64d_status_t status
);

    logic [1:0] pos_reg, pos_next;
    logic [5:0] carry_reg, carry_next;
    logic       err_reg, err_next;
    logic [5:0] carry_low4, carry_low2;
    logic       err_set;
    logic       have_byte;
    logic [7:0] byte_val;
    logic       err_total;

    assign carry_low4 = carry_reg & CARRY_LOW4_MASK;
    assign carry_low2 = carry_reg & CARRY_LOW2_MASK;

    always_comb
    begin
        // padding in the back half of a group is legal
        err_set   = digit.bad && !(digit.pad && pos_reg[1]);
        have_byte = 1'b0;
        byte_val  = 8'd0;
        carry_next = digit.value;
        case (pos_reg)
            GRP_POS_FIRST:
            begin
                carry_next = digit.value;
            end
            GRP_POS_SECOND:
            begin
                byte_val  = {carry_reg, digit.value[5:4]};
                have_byte = 1'b1;
            end
            GRP_POS_THIRD:
            begin
                byte_val  = {carry_low4[3:0], digit.value[5:2]};
                have_byte = !digit.pad;
            end
            GRP_POS_FOURTH:
            begin
                byte_val   = {carry_low2[1:0], digit.value};
                have_byte  = !digit.pad;
                carry_next = 6'd0;
            end
            default:
            begin
                carry_next = 6'd0;
            end
        endcase
        if (!have_byte)
        begin
            byte_val = 8'd0;
        end

        // a string ending on the first character of a group is invalid
        err_total = err_reg || err_set || (last_char && pos_reg == GRP_POS_FIRST);

        has_result          = have_byte || last_char;
        result.byte_out     = byte_val;
        result.byte_valid   = have_byte;
        result.last_out     = last_char;
        result.decode_error = last_char && err_total;

        pos_next = pos_reg + 2'd1;
        err_next = err_reg || err_set;
        if (last_char)
        begin
            pos_next   = GRP_POS_FIRST;
            carry_next = 6'd0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= GRP_POS_FIRST;
            carry_reg <= 6'd0;
            err_reg   <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg   <= pos_next;
            carry_reg <= carry_next;
            err_reg   <= err_next;
        end
    end

    assign status.pos = pos_reg;
    assign status.err = err_reg;

endmodule

### src/base64url_stream_decoder.sv
// A character accepted is held in the input register, decoded there, and its word is loaded into the output register.
// Throughput: one character per cycle; the input register and the output register
// each take a new word while the one ahead moves on, so only output stalls slow it.
// Characters that complete no byte and do not end a string give no output word.
// Reset (rst_n low, asynchronous) empties both registers and clears the group state.
module base64url_stream_decoder
    import b64d_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    b64d_char_if.sink   chars,
    b64d_byte_if.source bytes
);

    logic         s1_valid_reg;
    logic [7:0]   s1_char_reg;
    logic         s1_last_reg;
    logic         out_valid_reg;
    b64d_result_t out_reg;

    b64d_digit_t  digit;
    b64d_result_t result;
    b64d_status_t status;
    logic         has_result;
    logic         out_take;
    logic         s1_fire;

    assign out_take     = !out_valid_reg || bytes.ready;
    assign s1_fire      = s1_valid_reg && (!has_result || out_take);
    assign chars.ready  = !s1_valid_reg || s1_fire;

    b64d_digit_map u_digit_map (
        .char_in (s1_char_reg),
        .digit   (digit)
    );

    b64d_group u_group (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s1_fire),
        .digit      (digit),
        .last_char  (s1_last_reg),
        .has_result (has_result),
        .result     (result),
        .status     (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            s1_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            s1_char_reg <= chars.char_in;
            s1_last_reg <= chars.last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (bytes.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && has_result)
        begin
            out_reg <= result;
        end
    end

    assign bytes.valid        = out_valid_reg;
    assign bytes.byte_out     = out_reg.byte_out;
    assign bytes.byte_valid   = out_reg.byte_valid;
    assign bytes.last_out     = out_reg.last_out;
    assign bytes.decode_error = out_reg.decode_error;

    a_err_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        bytes.valid && bytes.decode_error |-> bytes.last_out)
        else $error("decode_error set on a word that does not close a string");

    a_word_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
        bytes.valid && !bytes.byte_valid |-> bytes.last_out && bytes.byte_out == 8'd0)
        else $error("output word carries neither a byte nor the end of a string");

    a_state_clears_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> status.pos == GRP_POS_FIRST && !status.err)
        else $error("group state not cleared after the end of a string");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !bytes.ready |-> !(s1_fire && has_result))
        else $error("stalled output word overwritten");

endmodule
